// ----- src/dkcl_pkg.sv -----
// Shared types, constants and the key layout table for the keypad code lock.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package dkcl_pkg;

   localparam int KEY_ROWS         = 4;
   localparam int KEY_COLS         = 4;
   localparam int KEY_COUNT        = KEY_ROWS * KEY_COLS;
   localparam int PASS_CHARS       = 4;
   localparam int CODE_LENGTH_DEF  = 4;
   localparam int TICK_MS_DEF      = 10;

   localparam int CHAR_W  = 8;
   localparam int TIME_W  = 16;
   localparam int COUNT_W = 8;

   localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
   localparam logic [CHAR_W-1:0] CH_STAR = 8'd42;
   localparam logic [CHAR_W-1:0] CH_HASH = 8'd35;
   localparam logic [CHAR_W-1:0] CH_NONE = 8'd0;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 3'd4;

   localparam logic [CHAR_W-1:0] PASS_RESET_0   = 8'd50;
   localparam logic [CHAR_W-1:0] PASS_RESET_1   = 8'd57;
   localparam logic [CHAR_W-1:0] PASS_RESET_2   = 8'd52;
   localparam logic [CHAR_W-1:0] PASS_RESET_3   = 8'd51;
   localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd40;

   // Scanner states.
   localparam logic [1:0] ST_SCANNING = 2'd0;
   localparam logic [1:0] ST_DEBOUNCE = 2'd1;
   localparam logic [1:0] ST_HELD     = 2'd2;

   typedef logic [PASS_CHARS-1:0][CHAR_W-1:0] pass_code_type;

   typedef struct packed {
      logic               accepted;
      logic               rejected;
      logic [COUNT_W-1:0] attempts;
   } lock_result_type;

   // Character of each key, row-major: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
   localparam logic [CHAR_W-1:0] KEY_CHARS [KEY_COUNT] = '{
      8'd49, 8'd50, 8'd51, 8'd65,
      8'd52, 8'd53, 8'd54, 8'd66,
      8'd55, 8'd56, 8'd57, 8'd67,
      8'd42, 8'd48, 8'd35, 8'd68
   };

endpackage

`default_nettype wire

// ----- src/dkcl_key_scan.sv -----
// Keypad scanner: priority encoder over the key matrix plus the
// scan / debounce / held state machine. Depends on dkcl_pkg.
`default_nettype none

module dkcl_key_scan
   import dkcl_pkg::*;
#(
   parameter int TICK_MS = TICK_MS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [KEY_COUNT-1:0] key_matrix,
   input  wire logic [TIME_W-1:0]    debounce_ms,
   output logic      [CHAR_W-1:0]    released_key
);

   logic [1:0]        state_ff, state_in;
   logic [CHAR_W-1:0] cand_ff, cand_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [CHAR_W-1:0] seen;
   logic [TIME_W:0]   elapsed_sum;

   // Lowest set bit wins.
   always_comb begin
      seen = CH_NONE;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (key_matrix[i]) begin
            seen = KEY_CHARS[i];
         end
      end
   end

   assign elapsed_sum = {1'b0, elapsed_ff} + (TIME_W + 1)'(TICK_MS);

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      elapsed_in   = elapsed_ff;
      released_key = CH_NONE;
      unique case (state_ff)
         ST_SCANNING: begin
            if (seen != CH_NONE) begin
               cand_in    = seen;
               elapsed_in = '0;
               state_in   = ST_DEBOUNCE;
            end
         end
         ST_DEBOUNCE: begin
            if (elapsed_ff >= debounce_ms) begin
               state_in = (seen != CH_NONE && seen == cand_ff) ? ST_HELD : ST_SCANNING;
            end
            elapsed_in = elapsed_sum[TIME_W] ? {TIME_W{1'b1}} : elapsed_sum[TIME_W-1:0];
         end
         ST_HELD: begin
            if (seen != cand_ff) begin
               // Only a clean release reports the key; a change of key drops it.
               if (seen == CH_NONE) begin
                  released_key = cand_ff;
               end
               state_in = ST_SCANNING;
            end
         end
         default: begin
            state_in = ST_SCANNING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SCANNING;
         cand_ff    <= CH_NONE;
         elapsed_ff <= '0;
      end else if (advance) begin
         state_ff   <= state_in;
         cand_ff    <= cand_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/dkcl_code_check.sv -----
// Entry buffer, passcode compare and saturating reject counter.
// Depends on dkcl_pkg.
`default_nettype none

module dkcl_code_check
   import dkcl_pkg::*;
#(
   parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic [CHAR_W-1:0] released_key,
   input  wire logic            alarm_active,
   input  wire pass_code_type   pass_code,
   output lock_result_type      result
);

   localparam int POS_W = $clog2(CODE_LENGTH + 1);
   localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

   logic [CHAR_W-1:0]  buf_ff [CODE_LENGTH];
   logic [CHAR_W-1:0]  buf_in [CODE_LENGTH];
   logic [CHAR_W-1:0]  want   [CODE_LENGTH];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]   wr_idx;
   logic               match;

   // Positions past the configured passcode compare against '0'.
   for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_want
      if (g < PASS_CHARS) begin : g_pass
         assign want[g] = pass_code[g];
      end else begin : g_zero
         assign want[g] = CH_ZERO;
      end
   end

   always_comb begin
      match = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (buf_ff[i] != want[i]) begin
            match = 1'b0;
         end
      end
   end

   assign wr_idx = (pos_ff >= POS_W'(CODE_LENGTH)) ? '0 : pos_ff[IDX_W-1:0];

   always_comb begin
      buf_in          = buf_ff;
      pos_in          = pos_ff;
      cnt_in          = cnt_ff;
      result.accepted = 1'b0;
      result.rejected = 1'b0;
      if (advance && released_key != CH_NONE) begin
         if (released_key == CH_HASH) begin
            if (alarm_active) begin
               if (match) begin
                  result.accepted = 1'b1;
                  cnt_in          = '0;
                  pos_in          = '0;
                  for (int i = 0; i < CODE_LENGTH; i++) begin
                     buf_in[i] = CH_ZERO;
                  end
               end else begin
                  result.rejected = 1'b1;
                  if (cnt_ff != {COUNT_W{1'b1}}) begin
                     cnt_in = cnt_ff + COUNT_W'(1);
                  end
               end
            end
         end else if (released_key == CH_STAR) begin
            pos_in = '0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
               buf_in[i] = CH_ZERO;
            end
         end else begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
               if (wr_idx == IDX_W'(i)) begin
                  buf_in[i] = released_key;
               end
            end
            pos_in = POS_W'(wr_idx) + POS_W'(1);
         end
      end
      result.attempts = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            buf_ff[i] <= CH_ZERO;
         end
      end else begin
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         buf_ff <= buf_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/debounced_keypad_code_lock_unit.sv -----
// Debounced 4x4 keypad code lock, top level.
//
// Each req transfer is one tick: req_tdata carries the pressed-key matrix
// and the alarm flag. Every tick produces exactly one rsp transfer with the
// key released on that tick (0 when none), the accept / reject flags of a
// passcode check and the running count of rejected codes.
//
// The tick's state update happens at the req transfer and its result sits in
// the output register from the next cycle on. Throughput is one tick per
// cycle while the receiver takes results, set by the single output register;
// req_tready stays high while that register is empty or being drained, so
// a stalled receiver holds the result and pauses the input after one item.
//
// The csr channel writes the passcode characters (indexes 0 to 3) and the
// debounce time in ms (index 4); other indexes are ignored. Write only
// while the block is idle. Reset restores passcode 2943, a 40 ms debounce,
// an entry buffer of '0' characters, a zero reject count and an empty
// output register.
`default_nettype none

module debounced_keypad_code_lock_unit
   import dkcl_pkg::*;
#(
   parameter int CODE_LENGTH = CODE_LENGTH_DEF,
   parameter int TICK_MS     = TICK_MS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,  // key_matrix[15:0], alarm_active[16]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [23:0]            rsp_tdata,  // released_key[7:0], code_accepted[8],
                                                   // code_rejected[9], wrong_attempts[17:10]
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]      csr_data
);

   pass_code_type     pass_ff;
   logic [TIME_W-1:0] debounce_ff;
   logic              rsp_valid_ff;
   logic [17:0]       rsp_data_ff, rsp_data_in;
   logic              advance;
   logic [CHAR_W-1:0] released_key;
   lock_result_type   result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff[0]  <= PASS_RESET_0;
         pass_ff[1]  <= PASS_RESET_1;
         pass_ff[2]  <= PASS_RESET_2;
         pass_ff[3]  <= PASS_RESET_3;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PASS_0:   pass_ff[0]  <= csr_data[CHAR_W-1:0];
            CSR_PASS_1:   pass_ff[1]  <= csr_data[CHAR_W-1:0];
            CSR_PASS_2:   pass_ff[2]  <= csr_data[CHAR_W-1:0];
            CSR_PASS_3:   pass_ff[3]  <= csr_data[CHAR_W-1:0];
            CSR_DEBOUNCE: debounce_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   dkcl_key_scan #(
      .TICK_MS (TICK_MS)
   ) u_key_scan (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .key_matrix   (req_tdata[15:0]),
      .debounce_ms  (debounce_ff),
      .released_key (released_key)
   );

   dkcl_code_check #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_code_check (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .released_key (released_key),
      .alarm_active (req_tdata[16]),
      .pass_code    (pass_ff),
      .result       (result)
   );

   assign rsp_data_in = {result.attempts, result.rejected, result.accepted, released_key};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for debounced_keypad_code_lock_unit: random and directed keypad
// ticks, a cycle-free predictor of the scanner, entry buffer and passcode check.
// Depends on dkcl_pkg and the block's RTL only.

module tb_top;
   import dkcl_pkg::*;

   // Tracks the lock the way the block should, one tick at a time.
   class code_lock_scoreboard;
      typedef struct {
         logic [CHAR_W-1:0]  released;
         logic               accepted;
         logic               rejected;
         logic [COUNT_W-1:0] attempts;
      } lock_outcome_type;

      logic [CHAR_W-1:0]  pass_code [PASS_CHARS];
      logic [TIME_W-1:0]  debounce_ms;
      logic [1:0]         scan_state;
      logic [CHAR_W-1:0]  candidate;
      logic [TIME_W-1:0]  elapsed;
      logic [CHAR_W-1:0]  entry [CODE_LENGTH_DEF];
      int unsigned        entry_pos;
      logic [COUNT_W-1:0] rejects;
      lock_outcome_type   due_outcomes [$];
      int                 errors;

      function new();
         pass_code[0] = PASS_RESET_0;
         pass_code[1] = PASS_RESET_1;
         pass_code[2] = PASS_RESET_2;
         pass_code[3] = PASS_RESET_3;
         debounce_ms  = DEBOUNCE_RESET;
         scan_state   = ST_SCANNING;
         candidate    = CH_NONE;
         elapsed      = '0;
         rejects      = '0;
         errors       = 0;
         clear_entry();
      endfunction

      function void clear_entry();
         foreach (entry[i]) entry[i] = CH_ZERO;
         entry_pos = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [TIME_W-1:0] value);
         case (idx) inside
            CSR_PASS_0, CSR_PASS_1, CSR_PASS_2, CSR_PASS_3: pass_code[idx] = value[CHAR_W-1:0];
            CSR_DEBOUNCE: debounce_ms = value;
            default: ;
         endcase
      endfunction

      function logic [CHAR_W-1:0] first_key(logic [KEY_COUNT-1:0] m);
         for (int i = 0; i < KEY_COUNT; i++)
            if (m[i]) return KEY_CHARS[i];
         return CH_NONE;
      endfunction

      function bit code_matches();
         logic [CHAR_W-1:0] want;
         for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
            want = (i < PASS_CHARS) ? pass_code[i] : CH_ZERO;
            if (entry[i] != want) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_tick(logic [23:0] d);
         logic [KEY_COUNT-1:0] m;
         logic                 alarm;
         logic [CHAR_W-1:0]    seen;
         lock_outcome_type     o;
         int unsigned          t;
         m          = d[15:0];
         alarm      = d[16];
         o.released = CH_NONE;
         o.accepted = 1'b0;
         o.rejected = 1'b0;
         case (scan_state)
            ST_SCANNING: begin
               seen = first_key(m);
               if (seen != CH_NONE) begin
                  candidate  = seen;
                  elapsed    = '0;
                  scan_state = ST_DEBOUNCE;
               end
            end
            ST_DEBOUNCE: begin
               if (elapsed >= debounce_ms) begin
                  seen = first_key(m);
                  if (seen != CH_NONE && seen == candidate) scan_state = ST_HELD;
                  else scan_state = ST_SCANNING;
               end
               t = elapsed + TICK_MS_DEF;
               if (t > 32'hFFFF) elapsed = 16'hFFFF;
               else elapsed = TIME_W'(t);
            end
            ST_HELD: begin
               seen = first_key(m);
               if (seen != candidate) begin
                  if (seen == CH_NONE) o.released = candidate;
                  scan_state = ST_SCANNING;
               end
            end
            default: scan_state = ST_SCANNING;
         endcase

         if (o.released == CH_HASH) begin
            if (alarm) begin
               if (code_matches()) begin
                  o.accepted = 1'b1;
                  rejects    = '0;
                  clear_entry();
               end else begin
                  o.rejected = 1'b1;
                  if (rejects != 8'hFF) rejects++;
               end
            end
         end else if (o.released == CH_STAR) begin
            clear_entry();
         end else if (o.released != CH_NONE) begin
            if (entry_pos >= CODE_LENGTH_DEF) entry_pos = 0;
            entry[entry_pos] = o.released;
            entry_pos++;
         end
         o.attempts = rejects;
         due_outcomes.push_back(o);
      endfunction

      function void flag_error(string what, int unsigned want, int unsigned got);
         errors++;
         if (errors <= 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      endfunction

      function void check_result(logic [23:0] d);
         lock_outcome_type o;
         if (due_outcomes.size() == 0) begin
            flag_error("unexpected result", 0, d);
            return;
         end
         o = due_outcomes.pop_front();
         if (d[7:0] !== o.released) flag_error("released_key", o.released, d[7:0]);
         if (d[8] !== o.accepted) flag_error("code_accepted", o.accepted, d[8]);
         if (d[9] !== o.rejected) flag_error("code_rejected", o.rejected, d[9]);
         if (d[17:10] !== o.attempts) flag_error("wrong_attempts", o.attempts, d[17:10]);
         if (d[23:18] !== 6'd0) flag_error("padding", 0, d[23:18]);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;   // key_matrix[15:0], alarm_active[16]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;        // released_key[7:0], code_accepted[8],
                                             // code_rejected[9], wrong_attempts[17:10]
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]      csr_data = '0;

   code_lock_scoreboard scb;
   int unsigned         ticks_sent = 0;
   bit                  idle_on = 1'b1;
   int                  rsp_stall = 0;

   debounced_keypad_code_lock_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Results are checked before the new tick is noted, so a stray result can never
   // consume the expectation of a tick accepted on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            scb.check_result(rsp_tdata);
            rsp_stall = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (req_tvalid && req_tready) scb.note_tick(req_tdata);
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at a falling edge with tvalid still high.
   task automatic send_tick(logic [KEY_COUNT-1:0] m, logic a);
      int gap;
      if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, a, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   function automatic int key_slot(logic [CHAR_W-1:0] ch);
      for (int i = 0; i < KEY_COUNT; i++)
         if (KEY_CHARS[i] == ch) return i;
      return 0;
   endfunction

   function automatic logic [CHAR_W-1:0] random_char();
      return KEY_CHARS[$urandom_range(0, KEY_COUNT - 1)];
   endfunction

   function automatic logic [CHAR_W-1:0] random_entry_char();
      logic [CHAR_W-1:0] ch;
      ch = random_char();
      while (ch == CH_STAR || ch == CH_HASH) ch = random_char();
      return ch;
   endfunction

   // Holds a matrix long enough to pass the debounce wait, then lets go. Untidy
   // presses add random keys above the winning one and vary the timing.
   task automatic press_matrix(logic [KEY_COUNT-1:0] m, logic a, bit tidy);
      int                   hold;
      int                   rel;
      logic [KEY_COUNT-1:0] lowbit;
      logic [KEY_COUNT-1:0] above;
      logic [KEY_COUNT-1:0] noise;
      hold   = scb.debounce_ms / TICK_MS_DEF + 3 + (tidy ? 0 : $urandom_range(0, 2));
      rel    = tidy ? 1 : $urandom_range(1, 3);
      lowbit = m & (~m + 16'd1);
      above  = ~((lowbit << 1) - 16'd1);
      repeat (hold) begin
         noise = KEY_COUNT'($urandom);
         if (tidy || $urandom_range(0, 3) != 0) noise = '0;
         send_tick(m | (noise & above), a);
      end
      repeat (rel) send_tick('0, a);
   endtask

   task automatic press_key(logic [CHAR_W-1:0] ch, logic a, bit tidy);
      press_matrix(16'd1 << key_slot(ch), a, tidy);
   endtask

   // Clear, four characters that are mostly the passcode, then the check.
   task automatic enter_code(logic a);
      press_key(CH_STAR, a, 1'b0);
      for (int i = 0; i < PASS_CHARS; i++)
         press_key(($urandom_range(0, 6) != 0) ? scb.pass_code[i] : random_char(), a, 1'b0);
      press_key(CH_HASH, a, 1'b0);
   endtask

   task automatic random_burst(int unsigned count);
      int unsigned stop_at;
      int          pick;
      int          n;
      logic        a;
      logic [KEY_COUNT-1:0] first;
      stop_at = ticks_sent + count;
      while (ticks_sent < stop_at) begin
         a    = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            enter_code(a);
         end else if (pick < 8) begin
            press_key(random_char(), a, 1'b0);
         end else if (pick == 8) begin
            n = $urandom_range(1, 4);
            repeat (n) send_tick(KEY_COUNT'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            // A bounce that may end early, or a roll onto another key while held.
            first = 16'd1 << $urandom_range(0, KEY_COUNT - 1);
            n = $urandom_range(1, scb.debounce_ms / TICK_MS_DEF + 4);
            repeat (n) send_tick(first, a);
            n = $urandom_range(0, 3);
            repeat (n) send_tick(16'd1 << $urandom_range(0, KEY_COUNT - 1), a);
            send_tick('0, a);
         end
      end
   endtask

   // Called at a falling edge; leaves csr_valid high for the caller to lower.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic load_config(logic [CHAR_W-1:0] c0, logic [CHAR_W-1:0] c1,
                              logic [CHAR_W-1:0] c2, logic [CHAR_W-1:0] c3,
                              logic [TIME_W-1:0] db, bit probe_unused);
      write_csr(CSR_PASS_0, {8'($urandom), c0});
      write_csr(CSR_PASS_1, {8'($urandom), c1});
      write_csr(CSR_PASS_2, {8'($urandom), c2});
      write_csr(CSR_PASS_3, {8'($urandom), c3});
      write_csr(CSR_DEBOUNCE, db);
      if (probe_unused)
         for (int i = CSR_DEBOUNCE + 1; i < (1 << CSR_INDEX_W); i++)
            write_csr(CSR_INDEX_W'(i), TIME_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (scb.due_outcomes.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin
      scb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset passcode and debounce time.
      random_burst(60);
      wait_idle();

      // Zero debounce, with directed checks of the special cases first.
      load_config(random_entry_char(), random_entry_char(), random_entry_char(),
                  random_entry_char(), 16'd0, 1'b1);
      send_tick('0, 1'b0);
      press_matrix(16'hFFFF, 1'b1, 1'b1);
      press_matrix(16'h8000, 1'b0, 1'b1);
      press_key(CH_STAR, 1'b1, 1'b1);
      press_key(CH_HASH, 1'b1, 1'b1);
      for (int i = 0; i < PASS_CHARS; i++) press_key(scb.pass_code[i], 1'b0, 1'b1);
      press_key(CH_HASH, 1'b0, 1'b1);
      press_key(CH_HASH, 1'b1, 1'b1);
      random_burst(50);
      wait_idle();

      // A passcode no key can produce; enough rejects to saturate the count.
      // With no debounce wait a press takes two ticks and the release a third.
      load_config(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd0, 1'b0);
      repeat (257) begin
         send_tick(16'd1 << key_slot(CH_HASH), 1'b1);
         send_tick(16'd1 << key_slot(CH_HASH), 1'b1);
         send_tick('0, 1'b1);
      end
      random_burst(20);
      wait_idle();

      // Longest debounce wait: a bounce that is never confirmed.
      load_config(random_entry_char(), random_entry_char(), random_entry_char(),
                  random_entry_char(), 16'hFFFF, 1'b0);
      repeat (50) send_tick(16'd1 << $urandom_range(0, KEY_COUNT - 1), 1'b1);
      send_tick('0, 1'b1);
      wait_idle();

      load_config(random_entry_char(), random_entry_char(), random_entry_char(),
                  random_entry_char(), TIME_W'($urandom_range(0, 60)), 1'b0);
      random_burst(60);

      wait_idle();
      repeat (5) @(posedge clock);
      if (scb.errors == 0 && scb.due_outcomes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
